[hdl/dqp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types and constants of the quadrature DDS oscillator with Park stage.
// ----------------------------------------------------------------------------
package dqp_pkg;

    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 10;
    localparam int REF_W    = 11;
    localparam int AB_W     = 16;
    localparam int PROD_W   = AB_W + REF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int OUT_W    = 26;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [REF_W-1:0] CENTER_OFFSET = 11'sd511;
    localparam logic [PHASE_W-1:0]      PHASE_270     = 32'hC000_0000;
    localparam logic signed [SUM_W-1:0] OUT_MAX       = 28'sd33554431;
    localparam logic signed [SUM_W-1:0] OUT_MIN       = -28'sd33554432;

    localparam logic [CFG_IDX_W-1:0] CFG_TUNING_WORD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_REFS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFORM_MODE = 2'd2;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_PARK     = 2'd1;
    localparam logic [1:0] MODE_INV_PARK = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_b;
        logic signed [OUT_W-1:0] out_a;
        logic signed [REF_W-1:0] ref_cosine;
        logic signed [REF_W-1:0] ref_sine;
        logic signed [REF_W-1:0] feedback;
    } t_result;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAX) begin
            r = OUT_MAX[OUT_W-1:0];
        end else if (v < OUT_MIN) begin
            r = OUT_MIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/dqp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module dqp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/dds_quadrature_osc_park.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_quadrature_osc_park
// Quadrature DDS oscillator with optional Park / inverse Park rotation.
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel. tuser selects the function:
// 0 loads one sine table entry (no output word), 1 advances one tick.
// Each tick adds tuning word plus phase_inc to the 32-bit accumulator and
// reads the table at the accumulator, at accumulator plus phase_offset and
// 270 degrees further on; the three readings come from three copies of the
// table that every load writes together. One m_axis word leaves per tick.
// One word per cycle while tready is high, loads and ticks mixed freely.
// A tick passes phase add, table read, centering and multiply in order, then
// sum and saturate feed the output register.
// The output register plus one skid entry decouple the two sides: a stalled
// receiver lets one more result in; then tready drops and the pipe holds.
// Reset clears the accumulator, the pipeline and the registers
// (tuning word 0, centered references, no transform). Table contents are
// not cleared; every entry must be loaded before a tick reads it.
// Configuration is written through i_cfg_* while no word is in flight.
// ----------------------------------------------------------------------------
module dds_quadrature_osc_park #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // table_addr[9:0], table_word[19:10], phase_inc[51:20],
    // phase_offset[83:52], in_a[99:84], in_b[115:100], zero fill
    input  logic [119:0] i_s_axis_tdata,
    // func[0]
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // feedback[10:0], ref_sine[21:11], ref_cosine[32:22], out_a[58:33],
    // out_b[84:59], zero fill
    output logic [87:0]  o_m_axis_tdata
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int PW = dqp_pkg::PHASE_W;
    localparam int SW = dqp_pkg::SAMPLE_W;
    localparam int RW = dqp_pkg::REF_W;
    localparam int AW = dqp_pkg::AB_W;
    localparam int MW = dqp_pkg::PROD_W;
    localparam int UW = dqp_pkg::SUM_W;

    function automatic logic [ADDR_W-1:0] tbl_idx(input logic [PW-1:0] ph);
        logic [2*PW-1:0] p;
        p = 64'(ph) * 64'(TABLE_DEPTH);
        return p[PW +: ADDR_W];
    endfunction

    // input fields
    logic [9:0]           w_tbl_addr;
    logic [SW-1:0]        w_tbl_word;
    logic [PW-1:0]        w_phase_inc;
    logic [PW-1:0]        w_phase_off;
    logic signed [AW-1:0] w_in_a;
    logic signed [AW-1:0] w_in_b;

    assign w_tbl_addr  = i_s_axis_tdata[9:0];
    assign w_tbl_word  = i_s_axis_tdata[19:10];
    assign w_phase_inc = i_s_axis_tdata[51:20];
    assign w_phase_off = i_s_axis_tdata[83:52];
    assign w_in_a      = i_s_axis_tdata[99:84];
    assign w_in_b      = i_s_axis_tdata[115:100];

    // config
    logic [PW-1:0] r_tuning;
    logic          r_signed_refs;
    logic [1:0]    r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tuning      <= '0;
            r_signed_refs <= 1'b1;
            r_mode        <= dqp_pkg::MODE_NONE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                dqp_pkg::CFG_TUNING_WORD:    r_tuning      <= i_cfg_wdata;
                dqp_pkg::CFG_SIGNED_REFS:    r_signed_refs <= i_cfg_wdata[0];
                dqp_pkg::CFG_TRANSFORM_MODE: r_mode        <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_skid_v;
    logic r_out_v;
    logic w_en;
    logic w_accept;
    logic w_tick;
    logic w_load;

    assign w_en     = !r_skid_v;
    assign o_s_axis_tready = w_en;
    assign w_accept = i_s_axis_tvalid && w_en;
    assign w_tick   = w_accept && (i_s_axis_tuser == dqp_pkg::FUNC_TICK);
    assign w_load   = w_accept && (i_s_axis_tuser == dqp_pkg::FUNC_LOAD)
                      && (32'(w_tbl_addr) < 32'(TABLE_DEPTH));

    // stage 1: accumulator
    logic [PW-1:0]        r_accum;
    logic [PW-1:0]        n_accum;
    logic                 r_s1_v;
    logic [PW-1:0]        r_s1_off;
    logic signed [AW-1:0] r_s1_a;
    logic signed [AW-1:0] r_s1_b;

    assign n_accum = r_accum + r_tuning + w_phase_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_s1_v  <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= w_tick;
            if (w_tick) begin
                r_accum <= n_accum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_off <= w_phase_off;
            r_s1_a   <= w_in_a;
            r_s1_b   <= w_in_b;
        end
    end

    // table reads
    logic [PW-1:0]     w_ref_ph;
    logic [PW-1:0]     w_cos_ph;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [SW-1:0]     w_fb_raw;
    logic [SW-1:0]     w_rs_raw;
    logic [SW-1:0]     w_rc_raw;

    assign w_ref_ph  = r_accum + r_s1_off;
    assign w_cos_ph  = w_ref_ph + dqp_pkg::PHASE_270;
    assign w_wr_addr = ADDR_W'(w_tbl_addr);

    dqp_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_tbl_fb (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_tbl_word),
        .i_rd_en   (w_en),
        .i_rd_addr (tbl_idx(r_accum)),
        .o_rd_data (w_fb_raw)
    );

    dqp_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_tbl_rs (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_tbl_word),
        .i_rd_en   (w_en),
        .i_rd_addr (tbl_idx(w_ref_ph)),
        .o_rd_data (w_rs_raw)
    );

    dqp_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_tbl_rc (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_tbl_word),
        .i_rd_en   (w_en),
        .i_rd_addr (tbl_idx(w_cos_ph)),
        .o_rd_data (w_rc_raw)
    );

    // stage 2: read data valid
    logic                 r_s2_v;
    logic signed [AW-1:0] r_s2_a;
    logic signed [AW-1:0] r_s2_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_a <= r_s1_a;
            r_s2_b <= r_s1_b;
        end
    end

    logic signed [RW-1:0] w_fb;
    logic signed [RW-1:0] w_rs;
    logic signed [RW-1:0] w_rc;

    assign w_fb = $signed({1'b0, w_fb_raw}) - dqp_pkg::CENTER_OFFSET;
    assign w_rs = r_signed_refs ? $signed({1'b0, w_rs_raw}) - dqp_pkg::CENTER_OFFSET
                                : $signed({1'b0, w_rs_raw});
    assign w_rc = r_signed_refs ? $signed({1'b0, w_rc_raw}) - dqp_pkg::CENTER_OFFSET
                                : $signed({1'b0, w_rc_raw});

    // stage 3: centered samples
    logic                 r_s3_v;
    logic signed [RW-1:0] r_s3_fb;
    logic signed [RW-1:0] r_s3_rs;
    logic signed [RW-1:0] r_s3_rc;
    logic signed [AW-1:0] r_s3_a;
    logic signed [AW-1:0] r_s3_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_fb <= w_fb;
            r_s3_rs <= w_rs;
            r_s3_rc <= w_rc;
            r_s3_a  <= r_s2_a;
            r_s3_b  <= r_s2_b;
        end
    end

    // stage 4: products
    logic                 r_s4_v;
    logic signed [RW-1:0] r_s4_fb;
    logic signed [RW-1:0] r_s4_rs;
    logic signed [RW-1:0] r_s4_rc;
    logic signed [MW-1:0] r_ac;
    logic signed [MW-1:0] r_bs;
    logic signed [MW-1:0] r_bc;
    logic signed [MW-1:0] r_as;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (w_en) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_fb <= r_s3_fb;
            r_s4_rs <= r_s3_rs;
            r_s4_rc <= r_s3_rc;
            r_ac    <= MW'(r_s3_a * r_s3_rc);
            r_bs    <= MW'(r_s3_b * r_s3_rs);
            r_bc    <= MW'(r_s3_b * r_s3_rc);
            r_as    <= MW'(r_s3_a * r_s3_rs);
        end
    end

    // sums and saturation
    logic signed [UW-1:0] w_sum_a;
    logic signed [UW-1:0] w_sum_b;
    dqp_pkg::t_result     w_res;

    always_comb begin
        unique case (r_mode)
            dqp_pkg::MODE_PARK: begin
                w_sum_a = UW'(r_ac) + UW'(r_bs);
                w_sum_b = UW'(r_bc) - UW'(r_as);
            end
            dqp_pkg::MODE_INV_PARK: begin
                w_sum_a = UW'(r_ac) - UW'(r_bs);
                w_sum_b = UW'(r_as) + UW'(r_bc);
            end
            default: begin
                w_sum_a = '0;
                w_sum_b = '0;
            end
        endcase
        w_res.feedback   = r_s4_fb;
        w_res.ref_sine   = r_s4_rs;
        w_res.ref_cosine = r_s4_rc;
        w_res.out_a      = dqp_pkg::sat_out(w_sum_a);
        w_res.out_b      = dqp_pkg::sat_out(w_sum_b);
    end

    // output register and skid entry
    logic             w_new_v;
    logic             w_out_free;
    dqp_pkg::t_result r_out;
    dqp_pkg::t_result r_skid;

    assign w_new_v    = r_s4_v && w_en;
    assign w_out_free = !r_out_v || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            r_out_v  <= r_skid_v || w_new_v;
            r_skid_v <= 1'b0;
        end else if (w_new_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (w_new_v) begin
            r_skid <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {3'b000, r_out};

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry holds a word while output register is empty");

    a_load_holds_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_axis_tuser == dqp_pkg::FUNC_LOAD)) |=> $stable(r_accum))
        else $error("table load moved the phase accumulator");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_m_axis_tready) |=> ($stable(r_s4_v) && r_skid_v))
        else $error("pipeline advanced while skid entry was full");

    a_tick_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> r_s1_v)
        else $error("accepted tick did not enter the pipeline");

endmodule

[verif/dqp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_checker
// Scoreboard for the quadrature DDS oscillator with Park stage.
// It watches the register port and both stream channels. It keeps its own
// copy of the phase accumulator, the sine table and the registers. For every
// accepted tick it computes the expected output word, then compares each
// output word with the oldest expected word, field by field.
// ----------------------------------------------------------------------------
module dqp_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    // table_addr[9:0], table_word[19:10], phase_inc[51:20],
    // phase_offset[83:52], in_a[99:84], in_b[115:100], zero fill
    input  logic [119:0] i_s_tdata,
    // func[0]
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // feedback[10:0], ref_sine[21:11], ref_cosine[32:22], out_a[58:33],
    // out_b[84:59], zero fill
    input  logic [87:0]  i_m_tdata,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_ticks,
    output int           o_loads,
    output int           o_words
);

    localparam longint SAT_HI = 64'sd33554431;
    localparam longint SAT_LO = -64'sd33554432;

    logic [dqp_pkg::SAMPLE_W-1:0] sine_copy [1024];
    logic [31:0]                  osc_phase;
    logic [31:0]                  tuning;
    logic                         centered_refs;
    logic [1:0]                   rot_mode;
    dqp_pkg::t_result             osc_words_due [$];
    dqp_pkg::t_result             got_word;
    dqp_pkg::t_result             want_word;

    task automatic flag_error(input string what);
        $display("ERROR %0t ns: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic longint clamp26(input longint v);
        longint r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r;
    endfunction

    task automatic predict_tick(
        input  logic [31:0]        inc,
        input  logic [31:0]        off,
        input  logic signed [15:0] a,
        input  logic signed [15:0] b,
        output dqp_pkg::t_result   r
    );
        logic [31:0] ref_ph;
        logic [31:0] cos_ph;
        int          fb;
        int          rs;
        int          rc;
        longint      oa;
        longint      ob;
        longint      sa;
        longint      sb;
        osc_phase = osc_phase + tuning + inc;
        ref_ph    = osc_phase + off;
        cos_ph    = ref_ph + dqp_pkg::PHASE_270;
        fb = int'(sine_copy[osc_phase[31:22]]) - 511;
        rs = int'(sine_copy[ref_ph[31:22]]);
        rc = int'(sine_copy[cos_ph[31:22]]);
        if (centered_refs) begin
            rs = rs - 511;
            rc = rc - 511;
        end
        oa = 0;
        ob = 0;
        if (rot_mode == dqp_pkg::MODE_PARK) begin
            oa = longint'(a) * rc + longint'(b) * rs;
            ob = longint'(b) * rc - longint'(a) * rs;
        end else if (rot_mode == dqp_pkg::MODE_INV_PARK) begin
            oa = longint'(a) * rc - longint'(b) * rs;
            ob = longint'(a) * rs + longint'(b) * rc;
        end
        sa = clamp26(oa);
        sb = clamp26(ob);
        r.feedback   = fb[10:0];
        r.ref_sine   = rs[10:0];
        r.ref_cosine = rc[10:0];
        r.out_a      = sa[25:0];
        r.out_b      = sb[25:0];
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            osc_phase     = '0;
            tuning        = '0;
            centered_refs = 1'b1;
            rot_mode      = dqp_pkg::MODE_NONE;
            osc_words_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    dqp_pkg::CFG_TUNING_WORD:    tuning = i_cfg_wdata;
                    dqp_pkg::CFG_SIGNED_REFS:    centered_refs = i_cfg_wdata[0];
                    dqp_pkg::CFG_TRANSFORM_MODE: rot_mode = i_cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got_word = dqp_pkg::t_result'(i_m_tdata[84:0]);
                if (osc_words_due.size() == 0) begin
                    flag_error("output word with no tick waiting");
                end else begin
                    want_word = osc_words_due.pop_front();
                    if (got_word.feedback !== want_word.feedback)
                        flag_error($sformatf("word %0d feedback got %0d want %0d",
                            o_words, got_word.feedback, want_word.feedback));
                    if (got_word.ref_sine !== want_word.ref_sine)
                        flag_error($sformatf("word %0d ref_sine got %0d want %0d",
                            o_words, got_word.ref_sine, want_word.ref_sine));
                    if (got_word.ref_cosine !== want_word.ref_cosine)
                        flag_error($sformatf("word %0d ref_cosine got %0d want %0d",
                            o_words, got_word.ref_cosine, want_word.ref_cosine));
                    if (got_word.out_a !== want_word.out_a)
                        flag_error($sformatf("word %0d out_a got %0d want %0d",
                            o_words, got_word.out_a, want_word.out_a));
                    if (got_word.out_b !== want_word.out_b)
                        flag_error($sformatf("word %0d out_b got %0d want %0d",
                            o_words, got_word.out_b, want_word.out_b));
                end
                o_words++;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == dqp_pkg::FUNC_LOAD) begin
                    sine_copy[i_s_tdata[9:0]] = i_s_tdata[19:10];
                    o_loads++;
                end else begin
                    predict_tick(i_s_tdata[51:20], i_s_tdata[83:52],
                                 i_s_tdata[99:84], i_s_tdata[115:100], want_word);
                    osc_words_due.push_back(want_word);
                    o_ticks++;
                end
            end
        end
        o_pending = osc_words_due.size();
    end

endmodule

[verif/tb_dds_quadrature_osc_park.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dds_quadrature_osc_park
// Stimulus and verdict for the quadrature DDS oscillator with Park stage.
// The sine table is loaded in full first. Directed ticks aimed at known table
// entries then hit the reset settings, the centered and raised extremes,
// rotation saturation and the unused mode. After that come random phases of
// loads and ticks under changing register settings and handshake pressure.
// dqp_checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_dds_quadrature_osc_park;

    localparam int         PHASES          = 12;
    localparam int         ITEMS_PER_PHASE = 85;
    localparam int         STALL_LIMIT     = 5000;
    localparam logic [1:0] MODE_RESERVED   = 2'd3;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_addr  = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [87:0]  m_tdata;

    int          fail_count;
    int          pending;
    int          ticks;
    int          loads;
    int          words;
    int          src_idle  = 11;
    int          dst_idle  = 63;
    int          stall_cnt = 0;
    int          settings_cnt = 0;
    logic [31:0] steer_phase = '0;
    logic [31:0] tuning_now  = '0;

    dds_quadrature_osc_park dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    dqp_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_ticks      (ticks),
        .o_loads      (loads),
        .o_words      (words)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= dst_idle);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("no word moved for %0d cycles", STALL_LIMIT);
            $display("dds_quadrature_osc_park verification failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_step();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h0000_0000;
            1:       v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] mode_for(input int p);
        logic [1:0] m;
        case (p % 4)
            0:       m = dqp_pkg::MODE_NONE;
            1:       m = dqp_pkg::MODE_PARK;
            2:       m = dqp_pkg::MODE_INV_PARK;
            default: m = MODE_RESERVED;
        endcase
        return m;
    endfunction

    // valid stays high from one word to the next; it only drops for a gap
    task automatic put_word(input logic func, input logic [119:0] data);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_load(input logic [9:0] addr, input logic [9:0] value);
        logic [99:0] junk;
        junk = 100'({$urandom, $urandom, $urandom, $urandom});
        put_word(dqp_pkg::FUNC_LOAD, {junk, value, addr});
    endtask

    task automatic send_tick(input logic [31:0] inc, input logic [31:0] off,
                             input logic [15:0] a, input logic [15:0] b);
        logic [19:0] junk;
        junk = 20'($urandom);
        put_word(dqp_pkg::FUNC_TICK, {4'd0, b, a, off, inc, junk});
        steer_phase = steer_phase + tuning_now + inc;
    endtask

    // lands the accumulator on table entry fb_idx and the sine reference on ref_idx
    task automatic aim_tick(input logic [9:0] fb_idx, input logic [9:0] ref_idx,
                            input logic [15:0] a, input logic [15:0] b);
        logic [21:0] fine_fb;
        logic [21:0] fine_ref;
        logic [31:0] target;
        fine_fb  = 22'($urandom);
        fine_ref = 22'($urandom);
        target   = {fb_idx, fine_fb};
        send_tick(target - steer_phase - tuning_now, {ref_idx, fine_ref} - target, a, b);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] tw, input logic centered,
                                  input logic [1:0] mode);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= dqp_pkg::CFG_TUNING_WORD;
        cfg_wdata <= tw;
        @(posedge clk);
        cfg_addr  <= dqp_pkg::CFG_SIGNED_REFS;
        cfg_wdata <= {31'd0, centered};
        @(posedge clk);
        cfg_addr  <= dqp_pkg::CFG_TRANSFORM_MODE;
        cfg_wdata <= {30'd0, mode};
        @(posedge clk);
        cfg_we <= 1'b0;
        tuning_now = tw;
        settings_cnt++;
    endtask

    initial begin
        int          p;
        int          n;
        int          k;
        logic [31:0] tw;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // lower half full scale, upper half zero
        for (k = 0; k < 1024; k++) begin
            send_load(k[9:0], (k < 512) ? 10'h3FF : 10'h000);
        end

        // reset settings: centered refs, no rotation
        send_tick(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000);
        send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF);

        apply_settings(32'h0000_0000, 1'b1, dqp_pkg::MODE_PARK);
        aim_tick(10'd0,   10'd300, 16'h7FFF, 16'h7FFF);
        aim_tick(10'd600, 10'd600, 16'h8000, 16'h8000);
        aim_tick(10'd100, 10'd800, 16'h8000, 16'h7FFF);

        // raised refs drive the rotation into saturation
        apply_settings(32'h0000_0000, 1'b0, dqp_pkg::MODE_PARK);
        aim_tick(10'd0,   10'd300, 16'h7FFF, 16'h7FFF);
        aim_tick(10'd0,   10'd300, 16'h8000, 16'h8000);
        aim_tick(10'd0,   10'd300, 16'h8000, 16'h7FFF);

        apply_settings(32'hFFFF_FFFF, 1'b0, dqp_pkg::MODE_INV_PARK);
        aim_tick(10'd700, 10'd300, 16'h7FFF, 16'h8000);
        aim_tick(10'd200, 10'd100, 16'h8000, 16'h8000);
        aim_tick(10'd512, 10'd900, 16'h0001, 16'hFFFF);

        apply_settings(32'h0040_0000, 1'b1, dqp_pkg::MODE_INV_PARK);
        aim_tick(10'd300, 10'd300, 16'h8000, 16'h7FFF);
        send_tick(32'h0040_0000, 32'h8000_0000, 16'h5555, 16'hAAAA);

        apply_settings(32'h0000_0000, 1'b1, MODE_RESERVED);
        aim_tick(10'd0, 10'd300, 16'h7FFF, 16'h7FFF);
        send_tick(32'h8000_0000, 32'h4000_0000, 16'hAAAA, 16'h5555);

        for (p = 0; p < PHASES; p++) begin
            src_idle = (p < 4) ? 11 : (p < 8) ? 63 : 0;
            dst_idle = (p < 4) ? 63 : (p < 8) ? 11 : 0;
            case (p)
                0:       tw = 32'h0000_0000;
                1:       tw = 32'hFFFF_FFFF;
                default: tw = $urandom;
            endcase
            apply_settings(tw, ((p + p / 4) % 2) == 1, mode_for(p));
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_load(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
                end else begin
                    send_tick(pick_step(), $urandom, pick_operand(), pick_operand());
                end
            end
        end

        settle();
        repeat (16) @(posedge clk);

        $display("Ran %0d table loads and %0d ticks under %0d register settings,",
                 loads, ticks, settings_cnt);
        $display("%0d output words compared, %0d mismatches.", words, fail_count);
        if (fail_count == 0) begin
            $display("dds_quadrature_osc_park verification clean");
        end else begin
            $display("dds_quadrature_osc_park verification failed");
        end
        $finish;
    end

endmodule
